FILE: rtl/core/dtc_pkg.sv
package dtc_pkg;

    localparam int CHAR_W  = 8;
    localparam int WHOLE_W = 26;
    localparam int FRAC_W  = 7;
    localparam int PLACE_W = 2;
    localparam int CENTS_W = 32;

    localparam logic [WHOLE_W-1:0] LIMIT_RESET = 26'd40000000;

    localparam logic [CHAR_W-1:0] CHAR_TERM  = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    localparam logic [PLACE_W-1:0] PLACES_MAX = 2'd2;

    typedef enum logic [1:0] {
        PH_WHOLE = 2'd0,
        PH_FRAC  = 2'd1,
        PH_ERR   = 2'd2
    } t_phase;

    typedef struct packed {
        t_phase               phase;
        logic [WHOLE_W-1:0]   whole;
        logic                 saw_digit;
        logic [FRAC_W-1:0]    frac;
        logic [PLACE_W-1:0]   places;
    } t_parse_state;

    localparam t_parse_state PARSE_CLEAR = '{
        phase:     PH_WHOLE,
        whole:     '0,
        saw_digit: 1'b0,
        frac:      '0,
        places:    '0
    };

endpackage

FILE: rtl/core/dtc_update.sv
module dtc_update (
    input  dtc_pkg::t_parse_state               i_state,
    input  logic [dtc_pkg::CHAR_W-1:0]          i_char,
    input  logic [dtc_pkg::WHOLE_W-1:0]         i_limit,
    output dtc_pkg::t_parse_state               o_next,
    output logic                                o_ok,
    output logic [dtc_pkg::CENTS_W-1:0]         o_cents
);
    import dtc_pkg::*;

    localparam int NEXT_W = WHOLE_W + 4;
    localparam int FMUL_W = FRAC_W + 3;

    logic                  is_digit;
    logic [3:0]            digit;
    logic [NEXT_W-1:0]     whole_ext;
    logic [NEXT_W-1:0]     next_whole;
    logic [FMUL_W-1:0]     frac_ext;
    logic [FRAC_W-1:0]     next_frac;
    logic [FRAC_W-1:0]     frac_scaled;
    logic                  good;
    logic [CENTS_W-1:0]    cents_raw;

    always_comb begin
        is_digit   = (i_char >= CHAR_ZERO) && (i_char <= CHAR_NINE);
        digit      = is_digit ? i_char[3:0] : 4'd0;
        whole_ext  = NEXT_W'(i_state.whole);
        next_whole = (whole_ext << 3) + (whole_ext << 1) + NEXT_W'(digit);
        frac_ext   = FMUL_W'(i_state.frac);
        next_frac  = FRAC_W'((frac_ext << 3) + (frac_ext << 1) + FMUL_W'(digit));

        // missing fraction places count as zero
        case (i_state.places)
            2'd0:    frac_scaled = '0;
            2'd1:    frac_scaled = FRAC_W'((frac_ext << 3) + (frac_ext << 1));
            default: frac_scaled = i_state.frac;
        endcase

        good      = ((i_state.phase == PH_WHOLE) || (i_state.phase == PH_FRAC))
                    && i_state.saw_digit;
        cents_raw = CENTS_W'(i_state.whole) * CENTS_W'(100) + CENTS_W'(frac_scaled);

        o_ok    = good;
        o_cents = good ? cents_raw : '0;
        o_next  = i_state;

        if (i_char == CHAR_TERM) begin
            o_next = PARSE_CLEAR;
        end else begin
            case (i_state.phase)
                PH_WHOLE: begin
                    if (is_digit) begin
                        o_next.saw_digit = 1'b1;
                        if (next_whole > NEXT_W'(i_limit)) begin
                            o_next.phase = PH_ERR;
                        end else begin
                            o_next.whole = WHOLE_W'(next_whole);
                        end
                    end else if ((i_char == CHAR_POINT) && i_state.saw_digit) begin
                        o_next.phase = PH_FRAC;
                    end else begin
                        o_next.phase = PH_ERR;
                    end
                end
                PH_FRAC: begin
                    if (is_digit) begin
                        if (i_state.places < PLACES_MAX) begin
                            o_next.frac   = next_frac;
                            o_next.places = i_state.places + 2'd1;
                        end
                    end else begin
                        o_next.phase = PH_ERR;
                    end
                end
                default: begin
                    o_next.phase = PH_ERR;
                end
            endcase
        end
    end

endmodule

FILE: rtl/core/decimal_text_to_cents_core.sv
// channel   direction  ports                      payload
// s_axis    in         i_s_axis_*, o_s_axis_tready  tdata[7:0] char_code
// m_axis    out        o_m_axis_*, i_m_axis_tready  tuser ok, tdata[31:0] cents
// cfg       in         i_cfg_*, o_cfg_ready         data[25:0] whole_limit
//
// one byte accepted per cycle unless a terminator waits on the result register;
// a byte passes an input register, then the parser state update, and a
// terminator's result is registered in the result register once that register is free
// only a terminator waits on the result register; other bytes never stall
// synchronous active-low reset clears parser state and valids and reloads the reset limit
module decimal_text_to_cents_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [dtc_pkg::CHAR_W-1:0]      i_s_axis_tdata,   // [7:0] char_code
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [dtc_pkg::CENTS_W-1:0]     o_m_axis_tdata,   // [31:0] cents
    output logic                            o_m_axis_tuser,   // [0] ok
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dtc_pkg::WHOLE_W-1:0]     i_cfg_data        // [25:0] whole_limit
);
    import dtc_pkg::*;

    logic                   r_in_valid;
    logic [CHAR_W-1:0]      r_in_char;
    t_parse_state           r_state;
    logic [WHOLE_W-1:0]     r_limit;
    logic                   r_out_valid;
    logic                   r_out_ok;
    logic [CENTS_W-1:0]     r_out_cents;

    t_parse_state           n_state;
    logic                   n_ok;
    logic [CENTS_W-1:0]     n_cents;

    logic                   is_term;
    logic                   out_free;
    logic                   advance;
    logic                   in_take;

    dtc_update u_update (
        .i_state (r_state),
        .i_char  (r_in_char),
        .i_limit (r_limit),
        .o_next  (n_state),
        .o_ok    (n_ok),
        .o_cents (n_cents)
    );

    assign is_term  = (r_in_char == CHAR_TERM);
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign advance  = r_in_valid && (!is_term || out_free);
    assign in_take  = i_s_axis_tvalid && o_s_axis_tready;

    assign o_s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_cents;
    assign o_m_axis_tuser  = r_out_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_state     <= PARSE_CLEAR;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_state <= n_state;
            end

            if (i_cfg_valid && o_cfg_ready) begin
                r_limit <= i_cfg_data;
            end

            if (advance && is_term) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_char <= i_s_axis_tdata;
        end
        if (advance && is_term) begin
            r_out_ok    <= n_ok;
            r_out_cents <= n_cents;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_ok |-> r_out_cents == '0)
        else $error("rejected item carries nonzero cents");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && is_term |=> r_state.phase == PH_WHOLE && !r_state.saw_digit
                               && r_state.whole == '0 && r_state.places == '0)
        else $error("parser state not cleared after terminator");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.places <= PLACES_MAX && r_state.frac <= FRAC_W'(99))
        else $error("fraction state out of range");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_m_axis_tready |=> r_out_valid && $stable(r_out_cents))
        else $error("stalled result lost or changed");

endmodule

FILE: tb/sv/tb_decimal_text_to_cents_core.sv
`timescale 1ns / 100ps
module tb_decimal_text_to_cents_core;
    import dtc_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int CYCLE_LIMIT   = 300000;
    localparam int QUIET_CHARS   = 150;
    localparam int RANDOM_CHARS  = 265;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 6;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic               ok;
        logic [CENTS_W-1:0] cents;
    } t_price;

    class price_tracker;
        t_price             expected_prices[$];
        logic [WHOLE_W-1:0] whole_limit;
        t_phase             phase;
        logic [WHOLE_W-1:0] whole;
        logic               saw_digit;
        logic [FRAC_W-1:0]  frac;
        logic [PLACE_W-1:0] places;
        int                 mismatches;
        int                 checked;
        int                 valid_prices;

        function new();
            whole_limit  = LIMIT_RESET;
            mismatches   = 0;
            checked      = 0;
            valid_prices = 0;
            clear_text();
        endfunction

        function void clear_text();
            phase     = PH_WHOLE;
            whole     = '0;
            saw_digit = 1'b0;
            frac      = '0;
            places    = '0;
        endfunction

        function int pending();
            return expected_prices.size();
        endfunction

        function void note_char(logic [CHAR_W-1:0] c);
            logic        is_digit;
            logic [3:0]  d;
            logic [31:0] next_whole;
            logic [63:0] total;
            int unsigned scaled;
            int          k;
            t_price      p;
            is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
            // ascii digits carry their value in the low nibble
            d = is_digit ? c[3:0] : 4'd0;
            if (c == CHAR_TERM) begin
                p.ok  = (phase == PH_WHOLE || phase == PH_FRAC) && saw_digit;
                total = '0;
                if (p.ok) begin
                    scaled = {25'd0, frac};
                    for (k = int'(places); k < PLACES_MAX; k++)
                        scaled = scaled * 10;
                    total = {38'd0, whole} * 64'd100 + {32'd0, scaled};
                end
                p.cents = total[CENTS_W-1:0];
                expected_prices.push_back(p);
                clear_text();
                return;
            end
            case (phase)
                PH_WHOLE: begin
                    if (is_digit) begin
                        next_whole = {6'd0, whole} * 10 + d;
                        saw_digit  = 1'b1;
                        if (next_whole > {6'd0, whole_limit})
                            phase = PH_ERR;
                        else
                            whole = next_whole[WHOLE_W-1:0];
                    end else if (c == CHAR_POINT && saw_digit) begin
                        phase = PH_FRAC;
                    end else begin
                        phase = PH_ERR;
                    end
                end
                PH_FRAC: begin
                    if (is_digit) begin
                        // digits past the second are dropped
                        if (places < PLACES_MAX) begin
                            frac   = FRAC_W'(frac * 10 + d);
                            places = places + 2'd1;
                        end
                    end else begin
                        phase = PH_ERR;
                    end
                end
                default: phase = PH_ERR;
            endcase
        endfunction

        function void check_price(logic ok, logic [CENTS_W-1:0] cents);
            t_price want;
            checked++;
            if (expected_prices.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("unexpected result: ok %0b cents %0d", ok, cents);
                return;
            end
            want = expected_prices.pop_front();
            if (want.ok)
                valid_prices++;
            if (ok !== want.ok || cents !== want.cents) begin
                mismatches++;
                if (mismatches <= REPORT_MAX)
                    $display("result %0d: got ok %0b cents %0d, expected ok %0b cents %0d",
                             checked, ok, cents, want.ok, want.cents);
            end
        endfunction
    endclass

    logic                i_clk     = 1'b0;
    logic                i_rst_n   = 1'b0;
    logic                s_tvalid  = 1'b0;
    logic [CHAR_W-1:0]   s_tdata   = '0;
    logic                m_tready  = 1'b0;
    logic                cfg_valid = 1'b0;
    logic [WHOLE_W-1:0]  cfg_data  = '0;
    logic                s_tready;
    logic                m_tvalid;
    logic [CENTS_W-1:0]  m_tdata;
    logic                m_tuser;
    logic                cfg_ready;

    price_tracker        tracker = new();
    logic [CHAR_W-1:0]   text[$];
    int unsigned         chars_sent  = 0;
    int unsigned         cycle_count = 0;
    bit                  tx_quiet    = 1'b0;
    bit                  rx_quiet    = 1'b0;
    bit                  hold_req    = 1'b0;
    int                  hold_left   = 0;

    decimal_text_to_cents_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("run timed out after %0d cycles", cycle_count);
            $display("FAILURE");
            $finish;
        end
    end

    // result side: random stalls plus one long hold-off on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (m_tvalid && m_tready)
                tracker.check_price(m_tuser, m_tdata);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
                m_tready <= 1'b0;
            end else begin
                m_tready <= rx_quiet ? 1'b1 : ($urandom_range(0, 99) >= 27);
            end
        end
    end

    task automatic send_char(input logic [CHAR_W-1:0] c);
        s_tdata  <= c;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        tracker.note_char(c);
        chars_sent++;
        if (!tx_quiet && $urandom_range(0, 99) < 27) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic send_text();
        foreach (text[i])
            send_char(text[i]);
        text.delete();
    endtask

    task automatic put_str(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            text.push_back(s[i]);
        text.push_back(CHAR_TERM);
    endtask

    task automatic put_number(input int unsigned v);
        logic [CHAR_W-1:0] digits[$];
        do begin
            digits.push_front(CHAR_ZERO + CHAR_W'(v % 10));
            v = v / 10;
        end while (v != 0);
        foreach (digits[i])
            text.push_back(digits[i]);
    endtask

    task automatic put_digits(input int n);
        repeat (n)
            text.push_back(CHAR_ZERO + CHAR_W'($urandom_range(0, 9)));
    endtask

    task automatic make_random_text(input logic [WHOLE_W-1:0] lim);
        int unsigned kind;
        int unsigned w;
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
            if ($urandom_range(0, 9) == 0)
                text.push_back(CHAR_ZERO);
            case ($urandom_range(0, 2))
                0: w = $urandom_range(0, 999);
                1: w = $urandom % ({6'd0, lim} + 1);
                default: begin
                    // straddle the limit
                    w = lim + $urandom_range(0, 4);
                    w = (w >= 2) ? w - 2 : 0;
                end
            endcase
            put_number(w);
            if ($urandom_range(0, 9) < 7) begin
                text.push_back(CHAR_POINT);
                put_digits($urandom_range(0, 4));
            end
            if (kind >= 60)
                text.insert($urandom_range(0, text.size()), CHAR_W'($urandom_range(1, 255)));
        end else if (kind < 85) begin
            case ($urandom_range(0, 2))
                0: begin
                    text.push_back(CHAR_POINT);
                    put_digits($urandom_range(1, 3));
                end
                1: begin
                    put_digits($urandom_range(1, 3));
                    text.push_back(CHAR_POINT);
                    put_digits($urandom_range(0, 2));
                    text.push_back(CHAR_POINT);
                    put_digits($urandom_range(0, 2));
                end
                default: ;
            endcase
        end else begin
            repeat ($urandom_range(1, 6))
                text.push_back(CHAR_W'($urandom_range(1, 255)));
        end
        text.push_back(CHAR_TERM);
    endtask

    task automatic run_random(input logic [WHOLE_W-1:0] lim, input int unsigned count);
        int unsigned start;
        start = chars_sent;
        while (chars_sent - start < count) begin
            make_random_text(lim);
            send_text();
        end
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (tracker.pending() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [WHOLE_W-1:0] v);
        cfg_data  <= v;
        cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        tracker.whole_limit = v;
    endtask

    initial begin
        logic [WHOLE_W-1:0] limits[$];
        limits = '{26'd0, 26'd42949671, 26'h3FFFFFF, 26'd999,
                   WHOLE_W'($urandom_range(1, 26'h3FFFFFE))};
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        put_str("");
        put_str("5.");
        put_str(".5");
        put_str("0.9051");
        put_str("1..2");
        text.push_back(8'hFF);
        text.push_back(8'h80);
        text.push_back(CHAR_TERM);
        send_text();

        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        run_random(LIMIT_RESET, QUIET_CHARS);
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        hold_req = 1'b1;
        run_random(LIMIT_RESET, RANDOM_CHARS);
        wait_idle();

        foreach (limits[i]) begin
            write_limit(limits[i]);
            run_random(limits[i], RANDOM_CHARS);
            wait_idle();
        end

        $display("%0d characters parsed into %0d results, %0d of them valid prices",
                 chars_sent, tracker.checked, tracker.valid_prices);
        $display("integer limits: reset value, zero, the 32-bit safe bound, all ones, 999, random");
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", tracker.mismatches);
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: decimal_text_to_cents_core.f
rtl/core/dtc_pkg.sv
rtl/core/dtc_update.sv
rtl/core/decimal_text_to_cents_core.sv
tb/sv/tb_decimal_text_to_cents_core.sv
